// File: src/pba_pkg.sv
// Shared types, codes and helpers for the page bitmap allocator.
package pba_pkg;

  localparam int MAP_WORDS_DEF = 1024;
  localparam int WORD_BITS     = 64;
  localparam int CNT_W         = 17;
  localparam int PAGE_W        = 16;
  localparam int QW            = 11;

  typedef enum logic [1:0] {
    FN_ALLOC = 2'd0,
    FN_FREE  = 2'd1,
    FN_CLEAR = 2'd2,
    FN_NOP   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ZERO    = 2'd1,
    ST_NOSPACE = 2'd2,
    ST_BOUNDS  = 2'd3
  } status_t;

  typedef struct packed {
    func_t               func;
    logic [CNT_W-1:0]    count;
    logic [PAGE_W-1:0]   page;
  } in_word_t;

  typedef struct packed {
    status_t             status;
    logic [PAGE_W-1:0]   start_page;
  } out_word_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DEC, S_CLR, S_SCAN, S_COMMIT, S_FILL, S_FRD, S_FWR, S_RESP
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SWEEP, OP_SCAN, OP_COMMIT, OP_FILL, OP_FRD, OP_FWR, OP_RESP
  } op_t;

  typedef struct packed {
    op_t     op;
    status_t res_status;
    logic    res_start;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  zero;
    logic  bounds;
    logic  span;
    logic  sweep_last;
    logic  hit;
    logic  scan_end;
    logic  fill_last;
    logic  free_last;
  } sts_t;

  // mask of the low n bits, n in 0..64
  function automatic logic [63:0] low_mask(input logic [6:0] n);
    logic [63:0] m;
    if (n >= 7'd64) m = '1;
    else m = (64'd1 << n) - 64'd1;
    return m;
  endfunction

endpackage

// File: src/page_bitmap_allocator_top.sv
// Clear sweeps every bitmap word; free reads and rewrites each bitmap word it touches.
// Allocate scans one word per cycle from word 0; for runs over 64 pages each whole
// word taken is then filled in turn. One request at a time.
// The bitmap memory has a write port and a read port, with one access per cycle.
// Reset: synchronous, active low; a clearing pass over all MAP_WORDS words sets every
// page free, with input stalled until it ends.
module page_bitmap_allocator_top import pba_pkg::*; #(
  parameter int MAP_WORDS = MAP_WORDS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  cmd_t cmd;
  sts_t sts;

  pba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  pba_dp #(.MAP_WORDS(MAP_WORDS)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// File: src/pba_dp.sv
// Datapath: bitmap memory, scan and fill counters, run search and free masks.
module pba_dp import pba_pkg::*; #(
  parameter int MAP_WORDS = MAP_WORDS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_data,
  input  cmd_t      cmd,
  output sts_t      sts,
  output out_word_t out_data
);

  localparam int AW = $clog2(MAP_WORDS);
  localparam int CW = AW + 1;
  localparam int PW = AW + 7;
  localparam int SW = ((AW > QW) ? AW : QW) + 1;
  localparam int TW = 20;
  localparam logic [TW-1:0] TOTAL = TW'(MAP_WORDS * WORD_BITS);

  logic [63:0] mem [MAP_WORDS];

  func_t            func_r;
  logic             zero_r, bounds_r, span_r, r_nz_r;
  logic [QW-1:0]    q_r;
  logic [63:0]      rmask_r, base_r;
  logic [6:0]       cnt7_r;
  logic [PW-1:0]    pos_r;
  logic [CNT_W-1:0] left_r;
  logic [CW-1:0]    a_r;
  logic             dv_r;
  logic [AW-1:0]    tag_r;
  logic [63:0]      mem_q_r;
  logic [QW-1:0]    run_r;
  logic [AW-1:0]    hit_addr_r, f_addr_r;
  logic [63:0]      hit_word_r;
  logic [15:0]      start_r;
  logic [QW-1:0]    f_left_r;
  out_word_t        out_data_r;

  logic             we, re, a_end;
  logic [AW-1:0]    wa, ra;
  logic [63:0]      wd;

  // small run search within one word
  logic             s_hit;
  logic [5:0]       s_idx;
  always_comb begin
    s_hit = 1'b0;
    s_idx = '0;
    for (int i = 63; i >= 0; i--) begin
      if ((7'(i) + cnt7_r <= 7'd64) && (((mem_q_r >> i) & base_r) == base_r)) begin
        s_hit = 1'b1;
        s_idx = 6'(i);
      end
    end
  end

  // large run tracking over whole words
  logic             full, lowok, l_hit, hit;
  logic [QW-1:0]    run_inc;
  logic [SW-1:0]    lw;
  logic [AW-1:0]    first_w;
  assign full    = &mem_q_r;
  assign lowok   = (mem_q_r & rmask_r) == rmask_r;
  assign run_inc = run_r + QW'(1);
  assign l_hit   = r_nz_r ? ((run_r == q_r) && lowok) : (full && (run_inc == q_r));
  assign lw      = SW'(tag_r) - SW'(q_r) + (r_nz_r ? SW'(0) : SW'(1));
  assign first_w = AW'(lw);
  assign hit     = dv_r && (span_r ? l_hit : s_hit);
  assign a_end   = (a_r == CW'(MAP_WORDS));

  // free mask for the word at pos
  logic [5:0]       fb;
  logic [6:0]       nb, n7, fe;
  logic [CNT_W-1:0] n17;
  logic [63:0]      fmask;
  logic [AW-1:0]    pos_w;
  assign fb    = pos_r[5:0];
  assign nb    = 7'd64 - {1'b0, fb};
  assign n17   = (left_r < CNT_W'(nb)) ? left_r : CNT_W'(nb);
  assign n7    = 7'(n17);
  assign fe    = {1'b0, fb} + n7;
  assign fmask = low_mask(fe) & ~low_mask({1'b0, fb});
  assign pos_w = pos_r[AW+5:6];

  // memory port selection
  always_comb begin
    we = 1'b0;
    re = 1'b0;
    wa = a_r[AW-1:0];
    ra = a_r[AW-1:0];
    wd = '1;
    unique case (cmd.op)
      OP_SWEEP:  we = 1'b1;
      OP_SCAN:   re = !a_end;
      OP_COMMIT: begin
        we = !span_r || r_nz_r;
        wa = hit_addr_r;
        wd = hit_word_r;
      end
      OP_FILL: begin
        we = 1'b1;
        wa = f_addr_r;
        wd = '0;
      end
      OP_FRD: begin
        re = 1'b1;
        ra = pos_w;
      end
      OP_FWR: begin
        we = 1'b1;
        wa = pos_w;
        wd = mem_q_r | fmask;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) mem_q_r <= mem[ra];
  end

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r  <= '0;
      dv_r <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          a_r  <= '0;
          dv_r <= 1'b0;
        end
        OP_SWEEP: a_r <= a_r + CW'(1);
        OP_SCAN: begin
          if (!a_end) a_r <= a_r + CW'(1);
          dv_r <= !a_end;
        end
        default: dv_r <= 1'b0;
      endcase
    end
  end

  // request registers and search results
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        func_r   <= in_data.func;
        zero_r   <= (in_data.count == '0);
        span_r   <= (in_data.count > CNT_W'(64));
        bounds_r <= (TW'(in_data.page) + TW'(in_data.count)) > TOTAL;
        q_r      <= in_data.count[16:6];
        r_nz_r   <= (in_data.count[5:0] != '0);
        rmask_r  <= low_mask({1'b0, in_data.count[5:0]});
        base_r   <= low_mask(in_data.count[6:0]);
        cnt7_r   <= in_data.count[6:0];
        pos_r    <= PW'(in_data.page);
        left_r   <= in_data.count;
        run_r    <= '0;
      end
      OP_SCAN: begin
        tag_r <= a_r[AW-1:0];
        if (hit) begin
          hit_addr_r <= tag_r;
          f_addr_r   <= first_w;
          f_left_r   <= q_r;
          if (span_r) begin
            hit_word_r <= mem_q_r & ~rmask_r;
            start_r    <= 16'({first_w, 6'd0});
          end else begin
            hit_word_r <= mem_q_r & ~(base_r << s_idx);
            start_r    <= 16'({tag_r, s_idx});
          end
        end else if (dv_r && span_r) begin
          run_r <= full ? run_inc : '0;
        end
      end
      OP_FILL: begin
        f_addr_r <= f_addr_r + AW'(1);
        f_left_r <= f_left_r - QW'(1);
      end
      OP_FWR: begin
        pos_r  <= pos_r + PW'(n7);
        left_r <= left_r - n17;
      end
      OP_RESP: begin
        out_data_r.status     <= cmd.res_status;
        out_data_r.start_page <= cmd.res_start ? start_r : '0;
      end
      default: ;
    endcase
  end

  assign sts.func       = func_r;
  assign sts.zero       = zero_r;
  assign sts.bounds     = bounds_r;
  assign sts.span       = span_r;
  assign sts.sweep_last = (a_r == CW'(MAP_WORDS - 1));
  assign sts.hit        = hit;
  assign sts.scan_end   = a_end && !dv_r;
  assign sts.fill_last  = (f_left_r == QW'(1));
  assign sts.free_last  = (left_r == n17);
  assign out_data       = out_data_r;

  a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_FILL) |-> (f_left_r != '0))
    else $error("fill with no words left");
  a_fwr_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_FWR) |-> (fmask != '0))
    else $error("free write with empty mask");
  a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    hit |-> dv_r)
    else $error("hit without read data");

endmodule

// File: src/pba_ctrl.sv
// Controller: sequences clear, scan, commit, fill and free steps.
module pba_ctrl import pba_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t  state_r, state_nxt;
  logic    out_valid_r, out_valid_nxt;
  status_t res_status_r, res_status_nxt;
  logic    res_start_r, res_start_nxt;

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      out_valid_r  <= 1'b0;
      res_status_r <= ST_OK;
      res_start_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      res_status_r <= res_status_nxt;
      res_start_r  <= res_start_nxt;
    end
  end

  // advance state and issue commands
  always_comb begin
    state_nxt      = state_r;
    res_status_nxt = res_status_r;
    res_start_nxt  = res_start_r;
    out_valid_nxt  = out_valid_r && out_stall;
    cmd.op         = OP_NONE;
    cmd.res_status = res_status_r;
    cmd.res_start  = res_start_r;
    unique case (state_r)
      S_INIT: begin
        cmd.op = OP_SWEEP;
        if (sts.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        res_start_nxt  = 1'b0;
        res_status_nxt = ST_OK;
        unique case (sts.func)
          FN_CLEAR: state_nxt = S_CLR;
          FN_NOP:   state_nxt = S_RESP;
          FN_FREE: begin
            if (sts.zero) begin
              res_status_nxt = ST_ZERO;
              state_nxt      = S_RESP;
            end else if (sts.bounds) begin
              res_status_nxt = ST_BOUNDS;
              state_nxt      = S_RESP;
            end else begin
              state_nxt = S_FRD;
            end
          end
          FN_ALLOC: begin
            if (sts.zero) begin
              res_status_nxt = ST_ZERO;
              state_nxt      = S_RESP;
            end else begin
              state_nxt = S_SCAN;
            end
          end
        endcase
      end
      S_CLR: begin
        cmd.op = OP_SWEEP;
        if (sts.sweep_last) state_nxt = S_RESP;
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (sts.hit) begin
          res_start_nxt = 1'b1;
          state_nxt     = S_COMMIT;
        end else if (sts.scan_end) begin
          res_status_nxt = ST_NOSPACE;
          state_nxt      = S_RESP;
        end
      end
      S_COMMIT: begin
        cmd.op    = OP_COMMIT;
        state_nxt = sts.span ? S_FILL : S_RESP;
      end
      S_FILL: begin
        cmd.op = OP_FILL;
        if (sts.fill_last) state_nxt = S_RESP;
      end
      S_FRD: begin
        cmd.op    = OP_FRD;
        state_nxt = S_FWR;
      end
      S_FWR: begin
        cmd.op    = OP_FWR;
        state_nxt = sts.free_last ? S_RESP : S_FRD;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          cmd.op        = OP_RESP;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_accept_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r == S_DEC))
    else $error("accepted word not decoded");
  a_commit_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT) |-> ($past(state_r) == S_SCAN))
    else $error("commit without scan hit");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r)
    else $error("result word dropped while stalled");

endmodule
